// File: hw/rtl/bpe_pkg.sv
// ----------------------------------------------------------------------------
// bpe_pkg
// Shared types and constants of the button press event state machine.
// ----------------------------------------------------------------------------
`default_nettype none

package bpe_pkg;

	localparam int unsigned TIME_W   = 32;
	localparam int unsigned INTVL_W  = 16;
	localparam int unsigned COUNT_W  = 4;
	localparam int unsigned CODE_W   = 3;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// Register indexes of the configuration channel
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_PERIOD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_COUNT  = 3'd4;

	// Register values after reset
	localparam logic [INTVL_W-1:0] RST_DEBOUNCE       = 16'd20;
	localparam logic [INTVL_W-1:0] RST_LONG_PRESS     = 16'd1000;
	localparam logic [INTVL_W-1:0] RST_REPEAT         = 16'd200;
	localparam logic [INTVL_W-1:0] RST_RELEASE_PERIOD = 16'd500;
	localparam logic [COUNT_W-1:0] RST_RELEASE_COUNT  = 4'd10;

	typedef enum logic [CODE_W-1:0] {
		MODE_IDLE     = 3'd0,
		MODE_DEBOUNCE = 3'd1,
		MODE_PRESSED  = 3'd2,
		MODE_REPEAT   = 3'd3,
		MODE_RELEASE  = 3'd4
	} mode_t;

	typedef enum logic [CODE_W-1:0] {
		EV_NONE    = 3'd0,
		EV_PRESS   = 3'd1,
		EV_LONG    = 3'd2,
		EV_REPEAT  = 3'd3,
		EV_RELEASE = 3'd4
	} event_t;

	typedef struct packed {
		logic [INTVL_W-1:0] debounce_ms;
		logic [INTVL_W-1:0] long_press_ms;
		logic [INTVL_W-1:0] repeat_ms;
		logic [INTVL_W-1:0] release_period_ms;
		logic [COUNT_W-1:0] release_repeats;
	} cfg_t;

	typedef struct packed {
		mode_t              mode;
		logic [TIME_W-1:0]  time_mark;
		logic [COUNT_W-1:0] release_counter;
	} state_t;

endpackage

`default_nettype wire

// File: hw/rtl/button_press_event_fsm.sv
// ----------------------------------------------------------------------------
// button_press_event_fsm
// Button poll state machine: debounce, press, long press, repeat and release
// events from an active-low pin level and a millisecond timestamp.
// ----------------------------------------------------------------------------
// Usage:
//   Each item on the s_ side is one poll: the pin level and the current
//   millisecond time. Each poll gives exactly one item on the m_ side with
//   the event code (none, press, long press, repeat, release) and the mode
//   after the poll.
//   Timing: a poll is registered in the input register on acceptance,
//   evaluated there, and its result registered in the result register that
//   drives m_tvalid and m_tdata. One poll per cycle is sustained while
//   m_tready stays high; the state update (one 32-bit subtract and four
//   compares) sits between the two registers and sets that rate.
//   Stall: while m_tready is low the result holds; the input register still
//   takes one more poll, after which s_tready falls until the output drains.
//   Configuration: cfg_ready is always high; write only while no poll is in
//   flight. Unknown indexes are ignored.
//   Reset: arst_n clears the pipeline, puts the machine in idle with a zero
//   time mark and release count, and loads the default intervals.
// ----------------------------------------------------------------------------
`default_nettype none

module button_press_event_fsm (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// poll input; tdata: [0] pin_level, [32:1] now_ms, [39:33] zero
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [39:0]                    s_tdata,
	// result output; tdata: [2:0] event_code, [5:3] mode_now, [7:6] zero
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [7:0]                          m_tdata,
	// configuration write channel
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [bpe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bpe_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bpe_pkg::*;

	cfg_t              cfg;
	state_t            state_q;
	state_t            state_nxt;
	event_t            ev_nxt;
	logic              valid_s1;
	logic              pin_s1;
	logic [TIME_W-1:0] now_s1;
	logic              valid_s2;
	event_t            event_s2;
	mode_t             mode_s2;
	logic              adv_s2;
	logic              adv_s1;

	assign cfg_ready = 1'b1;

	bpe_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Handshake: advance when the downstream stage is free or draining
	assign adv_s2   = ~valid_s2 | m_tready;
	assign adv_s1   = valid_s1 & adv_s2;
	assign s_tready = ~valid_s1 | adv_s2;

	// Hold the accepted poll in the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			pin_s1 <= s_tdata[0];
			now_s1 <= s_tdata[TIME_W:1];
		end
	end

	bpe_step u_step (
		.cfg       (cfg),
		.cur       (state_q),
		.pin_level (pin_s1),
		.now_ms    (now_s1),
		.nxt       (state_nxt),
		.ev        (ev_nxt)
	);

	// Update machine state as each poll moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode            <= MODE_IDLE;
			state_q.time_mark       <= '0;
			state_q.release_counter <= '0;
			valid_s2                <= 1'b0;
		end else begin
			if (adv_s1) begin
				state_q <= state_nxt;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			event_s2 <= ev_nxt;
			mode_s2  <= state_nxt.mode;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, mode_s2, event_s2};

`ifndef SYNTH
	// A press event always lands in the pressed mode
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && event_s2 == EV_PRESS) |-> (mode_s2 == MODE_PRESSED))
		else $error("press event without pressed mode");

	// Long-press and repeat events leave the machine in repeat mode
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (event_s2 == EV_LONG || event_s2 == EV_REPEAT))
		|-> (mode_s2 == MODE_REPEAT))
		else $error("long or repeat event outside repeat mode");

	// A release event leaves the machine in release or back in idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && event_s2 == EV_RELEASE)
		|-> (mode_s2 == MODE_RELEASE || mode_s2 == MODE_IDLE))
		else $error("release event in wrong mode");

	// State moves only when a poll moves into the result register
	assert property (@(posedge clk) disable iff (!arst_n)
		!$past(adv_s1) |-> $stable(state_q))
		else $error("state changed without a poll");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/bpe_cfg.sv
// ----------------------------------------------------------------------------
// bpe_cfg
// Configuration register bank; takes one register write per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bpe_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [bpe_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [bpe_pkg::CFG_DATA_W-1:0] wr_data,
	output bpe_pkg::cfg_t                       cfg
);
	import bpe_pkg::*;

	cfg_t cfg_q;

	// Decode the index and load the addressed register; drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms       <= RST_DEBOUNCE;
			cfg_q.long_press_ms     <= RST_LONG_PRESS;
			cfg_q.repeat_ms         <= RST_REPEAT;
			cfg_q.release_period_ms <= RST_RELEASE_PERIOD;
			cfg_q.release_repeats   <= RST_RELEASE_COUNT;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_DEBOUNCE:       cfg_q.debounce_ms       <= wr_data;
				CFG_LONG_PRESS:     cfg_q.long_press_ms     <= wr_data;
				CFG_REPEAT:         cfg_q.repeat_ms         <= wr_data;
				CFG_RELEASE_PERIOD: cfg_q.release_period_ms <= wr_data;
				CFG_RELEASE_COUNT:  cfg_q.release_repeats   <= wr_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: hw/rtl/bpe_step.sv
// ----------------------------------------------------------------------------
// bpe_step
// Next-state and event logic for one poll of the button.
// ----------------------------------------------------------------------------
`default_nettype none

module bpe_step (
	input  bpe_pkg::cfg_t                   cfg,
	input  bpe_pkg::state_t                 cur,
	input  wire logic                       pin_level,
	input  wire logic [bpe_pkg::TIME_W-1:0] now_ms,
	output bpe_pkg::state_t                 nxt,
	output bpe_pkg::event_t                 ev
);
	import bpe_pkg::*;

	logic               pressed;
	logic [TIME_W-1:0]  elapsed;
	logic               over_debounce;
	logic               over_long;
	logic               over_repeat;
	logic               over_release;
	logic [COUNT_W-1:0] count_inc;

	// Wrapping elapsed time and the strict interval compares
	assign pressed       = ~pin_level;
	assign elapsed       = now_ms - cur.time_mark;
	assign over_debounce = elapsed > {{(TIME_W-INTVL_W){1'b0}}, cfg.debounce_ms};
	assign over_long     = elapsed > {{(TIME_W-INTVL_W){1'b0}}, cfg.long_press_ms};
	assign over_repeat   = elapsed > {{(TIME_W-INTVL_W){1'b0}}, cfg.repeat_ms};
	assign over_release  = elapsed > {{(TIME_W-INTVL_W){1'b0}}, cfg.release_period_ms};

	// Advance the machine by one poll
	always_comb begin
		nxt       = cur;
		ev        = EV_NONE;
		count_inc = cur.release_counter;
		unique case (cur.mode)
			MODE_IDLE: begin
				if (pressed) begin
					nxt.mode      = MODE_DEBOUNCE;
					nxt.time_mark = now_ms;
				end
			end
			MODE_DEBOUNCE: begin
				if (over_debounce) begin
					if (pressed) begin
						nxt.mode      = MODE_PRESSED;
						nxt.time_mark = now_ms;
						ev            = EV_PRESS;
					end else begin
						nxt.mode = MODE_IDLE;
					end
				end
			end
			MODE_PRESSED: begin
				if (!pressed) begin
					nxt.mode = MODE_RELEASE;
				end else if (over_long) begin
					nxt.mode      = MODE_REPEAT;
					nxt.time_mark = now_ms;
					ev            = EV_LONG;
				end
			end
			MODE_REPEAT: begin
				if (!pressed) begin
					nxt.mode = MODE_RELEASE;
				end else if (over_repeat) begin
					nxt.time_mark = now_ms;
					ev            = EV_REPEAT;
				end
			end
			MODE_RELEASE: begin
				// Count a release event, then end the phase once the count is reached
				if (over_release) begin
					nxt.time_mark = now_ms;
					ev            = EV_RELEASE;
					count_inc     = cur.release_counter + COUNT_W'(1);
				end
				nxt.release_counter = count_inc;
				if (count_inc >= cfg.release_repeats) begin
					nxt.release_counter = '0;
					nxt.mode            = MODE_IDLE;
				end
			end
			default: begin
				nxt.mode = MODE_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire
